FILE: sv/badec_pkg.sv
// ----------------------------------------------------------------------------
// badec_pkg
// shared types, codes and region map of the bus address decoder
// ----------------------------------------------------------------------------
package badec_pkg;

    localparam int unsigned IRQ_W    = 11;
    localparam int unsigned OFF_W    = 21;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned LINE_W   = 4;
    localparam int unsigned S_DATA_W = 72;
    localparam int unsigned M_DATA_W = 72;

    localparam logic [LINE_W-1:0] IRQ_LINE_MAX = 4'd10;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_IRQ   = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2,
        SZ_RSVD = 2'd3
    } size_t;

    typedef enum logic [2:0] {
        TGT_LOCAL = 3'd0,
        TGT_RAM   = 3'd1,
        TGT_BIOS  = 3'd2,
        TGT_TIMER = 3'd3,
        TGT_DMA   = 3'd4,
        TGT_GP0   = 3'd5,
        TGT_GP1   = 3'd6
    } target_t;

    typedef enum logic [2:0] {
        ST_FWD    = 3'd0,
        ST_LOCAL  = 3'd1,
        ST_IGN    = 3'd2,
        ST_MIS    = 3'd3,
        ST_UNH    = 3'd4,
        ST_BADIRQ = 3'd5
    } status_t;

    localparam logic [31:0] RAM_END       = 32'h001f_ffff;
    localparam logic [31:0] EXP1_LO       = 32'h1f00_0000;
    localparam logic [31:0] EXP1_HI       = 32'h1f7f_ffff;
    localparam logic [31:0] MEMC_LO       = 32'h1f80_1000;
    localparam logic [31:0] MEMC_HI       = 32'h1f80_107f;
    localparam logic [31:0] IRQ_STAT_ADDR = 32'h1f80_1070;
    localparam logic [31:0] INT_MASK_ADDR = 32'h1f80_1074;
    localparam logic [31:0] DMA_LO        = 32'h1f80_1080;
    localparam logic [31:0] DMA_HI        = 32'h1f80_10ff;
    localparam logic [31:0] TMR_LO        = 32'h1f80_1100;
    localparam logic [31:0] TMR_HI        = 32'h1f80_112f;
    localparam logic [31:0] CD_LO         = 32'h1f80_1800;
    localparam logic [31:0] CD_HI         = 32'h1f80_1803;
    localparam logic [31:0] GPU_LO        = 32'h1f80_1810;
    localparam logic [31:0] GPU_HI        = 32'h1f80_1817;
    localparam logic [31:0] GPU_P1        = 32'h1f80_1814;
    localparam logic [31:0] SPU_LO        = 32'h1f80_1c00;
    localparam logic [31:0] SPU_HI        = 32'h1f80_1e7f;
    localparam logic [31:0] EXP2_LO       = 32'h1f80_2000;
    localparam logic [31:0] EXP2_HI       = 32'h1f80_2041;
    localparam logic [31:0] BIOS_LO       = 32'h1fc0_0000;
    localparam logic [31:0] BIOS_HI       = 32'h1fc7_ffff;
    localparam logic [31:0] CACHE_CTRL    = 32'hfffe_0130;

    localparam logic [31:0] KSEG0_MASK    = 32'h7fff_ffff;
    localparam logic [31:0] KSEG1_MASK    = 32'h1fff_ffff;
    localparam logic [31:0] BAD_WORD      = 32'hbadb_ad32;
    localparam logic [31:0] BAD_HALF      = 32'h0000_badb;
    localparam logic [31:0] EXP1_WORD     = 32'hffff_ffff;
    localparam logic [31:0] EXP1_HALF     = 32'h0000_ffff;
    localparam logic [31:0] EXP1_BYTE     = 32'h0000_00ff;

    // outcome of one access, as it goes to the result channel
    typedef struct packed {
        target_t            target;
        logic [OFF_W-1:0]   offset;
        logic [DATA_W-1:0]  rdata;
        status_t            status;
    } dec_t;

    // register side effects of one item
    typedef struct packed {
        logic               irq_set;
        logic [LINE_W-1:0]  line;
        logic               stat_ack;
        logic               mask_wr;
        logic [IRQ_W-1:0]   wval;
    } irq_op_t;

    function automatic logic in_rng(input logic [31:0] p, input logic [31:0] lo,
                                    input logic [31:0] hi);
        return (p >= lo) && (p <= hi);
    endfunction

    function automatic dec_t fwd(input target_t t, input logic [31:0] off);
        dec_t d;
        d.target = t;
        d.offset = off[OFF_W-1:0];
        d.rdata  = '0;
        d.status = ST_FWD;
        return d;
    endfunction

    function automatic dec_t loc(input status_t st, input logic [31:0] data);
        dec_t d;
        d.target = TGT_LOCAL;
        d.offset = '0;
        d.rdata  = data;
        d.status = st;
        return d;
    endfunction

endpackage

FILE: sv/badec_decode.sv
// ----------------------------------------------------------------------------
// badec_decode
// segment mapping, alignment check, interrupt request check and size-specific region decode
// ----------------------------------------------------------------------------
module badec_decode (
    input  badec_pkg::cmd_t                     cmd,
    input  badec_pkg::size_t                    size,
    input  logic [badec_pkg::ADDR_W-1:0]        addr,
    input  logic [badec_pkg::DATA_W-1:0]        wdata,
    input  logic [badec_pkg::LINE_W-1:0]        req_line,
    input  logic [badec_pkg::IRQ_W-1:0]         pending,
    input  logic [badec_pkg::IRQ_W-1:0]         mask,
    output badec_pkg::dec_t                     dec,
    output badec_pkg::irq_op_t                  op
);
    import badec_pkg::*;

    logic [31:0] p;
    logic [31:0] pend_w;
    logic [31:0] mask_w;
    logic        mis;
    logic        exp_any;

    // kseg0 keeps 31 bits, kseg1 keeps 29, the rest pass
    always_comb begin
        case (addr[31:29])
            3'd4:    p = addr & KSEG0_MASK;
            3'd5:    p = addr & KSEG1_MASK;
            default: p = addr;
        endcase
    end

    assign pend_w  = {{(32-IRQ_W){1'b0}}, pending};
    assign mask_w  = {{(32-IRQ_W){1'b0}}, mask};
    assign mis     = ((size == SZ_WORD) && (addr[1:0] != 2'b00))
                  || ((size == SZ_HALF) && addr[0]);
    assign exp_any = in_rng(p, EXP1_LO, EXP1_HI) || in_rng(p, EXP2_LO, EXP2_HI);

    always_comb begin
        dec         = loc(ST_UNH, '0);
        op.irq_set  = 1'b0;
        op.line     = req_line;
        op.stat_ack = 1'b0;
        op.mask_wr  = 1'b0;
        op.wval     = wdata[IRQ_W-1:0];

        case (cmd)
            CMD_IRQ: begin
                if (req_line <= IRQ_LINE_MAX) begin
                    op.irq_set = 1'b1;
                    dec        = loc(ST_LOCAL, '0);
                end else begin
                    dec = loc(ST_BADIRQ, '0);
                end
            end
            CMD_READ: begin
                if (size == SZ_RSVD) begin
                    dec = loc(ST_UNH, '0);
                end else if (mis) begin
                    dec = loc(ST_MIS, (size == SZ_WORD) ? BAD_WORD : BAD_HALF);
                end else if (size == SZ_WORD) begin
                    if (in_rng(p, TMR_LO, TMR_HI))       dec = fwd(TGT_TIMER, p - TMR_LO);
                    else if (p == IRQ_STAT_ADDR)         dec = loc(ST_LOCAL, pend_w);
                    else if (p == INT_MASK_ADDR)         dec = loc(ST_LOCAL, mask_w);
                    else if (p == GPU_LO)                dec = fwd(TGT_GP0, '0);
                    else if (p == GPU_P1)                dec = fwd(TGT_GP1, '0);
                    else if (in_rng(p, DMA_LO, DMA_HI))  dec = fwd(TGT_DMA, p - DMA_LO);
                    else if (in_rng(p, BIOS_LO, BIOS_HI)) dec = fwd(TGT_BIOS, p - BIOS_LO);
                    else if (p <= RAM_END)               dec = fwd(TGT_RAM, p);
                    else if (in_rng(p, SPU_LO, SPU_HI))  dec = loc(ST_IGN, '0);
                    else if (in_rng(p, EXP1_LO, EXP1_HI)) dec = loc(ST_LOCAL, EXP1_WORD);
                    else                                 dec = loc(ST_UNH, '0);
                end else if (size == SZ_HALF) begin
                    if (in_rng(p, TMR_LO, TMR_HI))       dec = fwd(TGT_TIMER, p - TMR_LO);
                    else if (p == IRQ_STAT_ADDR)         dec = loc(ST_LOCAL, pend_w);
                    else if (p == INT_MASK_ADDR)         dec = loc(ST_LOCAL, mask_w);
                    else if (in_rng(p, SPU_LO, SPU_HI))  dec = loc(ST_IGN, '0);
                    else if (p <= RAM_END)               dec = fwd(TGT_RAM, p);
                    else if (in_rng(p, EXP1_LO, EXP1_HI)) dec = loc(ST_LOCAL, EXP1_HALF);
                    else                                 dec = loc(ST_UNH, '0);
                end else begin
                    if (in_rng(p, TMR_LO, TMR_HI))       dec = loc(ST_UNH, '0);
                    else if (in_rng(p, CD_LO, CD_HI))    dec = loc(ST_IGN, '0);
                    else if (in_rng(p, EXP1_LO, EXP1_HI)) dec = loc(ST_LOCAL, EXP1_BYTE);
                    else if (in_rng(p, BIOS_LO, BIOS_HI)) dec = fwd(TGT_BIOS, p - BIOS_LO);
                    else if (p <= RAM_END)               dec = fwd(TGT_RAM, p);
                    else                                 dec = loc(ST_UNH, '0);
                end
            end
            CMD_WRITE: begin
                if (size == SZ_RSVD) begin
                    dec = loc(ST_UNH, '0);
                end else if (mis) begin
                    dec = loc(ST_MIS, '0);
                end else if (size inside {SZ_WORD, SZ_HALF}) begin
                    if (in_rng(p, TMR_LO, TMR_HI)) begin
                        dec = fwd(TGT_TIMER, p - TMR_LO);
                    end else if (p == IRQ_STAT_ADDR) begin
                        op.stat_ack = 1'b1;
                        dec         = loc(ST_LOCAL, '0);
                    end else if (p == INT_MASK_ADDR) begin
                        op.mask_wr = 1'b1;
                        dec        = loc(ST_LOCAL, '0);
                    end else if (size == SZ_WORD) begin
                        if (p == CACHE_CTRL)                  dec = loc(ST_IGN, '0);
                        else if (p == GPU_LO)                 dec = fwd(TGT_GP0, '0);
                        else if (p == GPU_P1)                 dec = fwd(TGT_GP1, '0);
                        else if (in_rng(p, DMA_LO, DMA_HI))   dec = fwd(TGT_DMA, p - DMA_LO);
                        else if (in_rng(p, MEMC_LO, MEMC_HI)) dec = loc(ST_IGN, '0);
                        else if (in_rng(p, SPU_LO, SPU_HI))   dec = loc(ST_IGN, '0);
                        else if (p <= RAM_END)                dec = fwd(TGT_RAM, p);
                        else if (in_rng(p, BIOS_LO, BIOS_HI)) dec = loc(ST_IGN, '0);
                        else if (exp_any)                     dec = loc(ST_IGN, '0);
                        else                                  dec = loc(ST_UNH, '0);
                    end else begin
                        if (in_rng(p, SPU_LO, SPU_HI))        dec = loc(ST_IGN, '0);
                        else if (p <= RAM_END)                dec = fwd(TGT_RAM, p);
                        else if (in_rng(p, MEMC_LO, MEMC_HI)) dec = loc(ST_IGN, '0);
                        else if (in_rng(p, BIOS_LO, BIOS_HI)) dec = loc(ST_IGN, '0);
                        else if (in_rng(p, GPU_LO, GPU_HI))   dec = loc(ST_UNH, '0);
                        else if (in_rng(p, DMA_LO, DMA_HI))   dec = loc(ST_UNH, '0);
                        else if (exp_any)                     dec = loc(ST_IGN, '0);
                        else                                  dec = loc(ST_UNH, '0);
                    end
                end else begin
                    if (in_rng(p, TMR_LO, TMR_HI))        dec = loc(ST_UNH, '0);
                    else if (in_rng(p, CD_LO, CD_HI))     dec = loc(ST_IGN, '0);
                    else if (in_rng(p, EXP2_LO, EXP2_HI)) dec = loc(ST_IGN, '0);
                    else if (in_rng(p, SPU_LO, SPU_HI))   dec = loc(ST_IGN, '0);
                    else if (p <= RAM_END)                dec = fwd(TGT_RAM, p);
                    else if (in_rng(p, MEMC_LO, MEMC_HI)) dec = loc(ST_IGN, '0);
                    else if (in_rng(p, BIOS_LO, BIOS_HI)) dec = loc(ST_IGN, '0);
                    else if (in_rng(p, EXP1_LO, EXP1_HI)) dec = loc(ST_IGN, '0);
                    else                                  dec = loc(ST_UNH, '0);
                end
            end
            default: begin
                dec = loc(ST_UNH, '0);
            end
        endcase
    end

endmodule

FILE: sv/badec_irq_regs.sv
// ----------------------------------------------------------------------------
// badec_irq_regs
// interrupt status and mask registers
// ----------------------------------------------------------------------------
module badec_irq_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            upd,
    input  badec_pkg::irq_op_t              op,
    output logic [badec_pkg::IRQ_W-1:0]     pending,
    output logic [badec_pkg::IRQ_W-1:0]     mask,
    output logic [badec_pkg::IRQ_W-1:0]     pending_after
);
    import badec_pkg::*;

    logic [IRQ_W-1:0] pending_reg;
    logic [IRQ_W-1:0] pending_next;
    logic [IRQ_W-1:0] mask_reg;
    logic [IRQ_W-1:0] mask_next;
    logic [IRQ_W-1:0] set_bits;

    assign set_bits = op.irq_set ? (IRQ_W'(1) << op.line) : '0;

    // status write acknowledges, irq request sets
    assign pending_after = (pending_reg | set_bits) & ~(op.stat_ack ? op.wval : '0);
    assign pending_next  = upd ? pending_after : pending_reg;
    assign mask_next     = (upd && op.mask_wr) ? op.wval : mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            mask_reg    <= '0;
        end else begin
            pending_reg <= pending_next;
            mask_reg    <= mask_next;
        end
    end

    assign pending = pending_reg;
    assign mask    = mask_reg;

endmodule

FILE: sv/bus_address_decoder_with_irq_regs_top.sv
// ----------------------------------------------------------------------------
// bus_address_decoder_with_irq_regs_top
// cpu bus address decoder with interrupt status and mask registers
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one cpu read, cpu write or interrupt request per word,
//   the command in s_tuser and the access fields in s_tdata.
//   m_ channel returns one result word per input word, in order: target,
//   offset, local read data and the interrupt status after the item in
//   m_tdata, the outcome code in m_tuser.
//   the input register feeds the address decode, whose outcome is captured
//   in the result register; m_tvalid is driven from the result register.
//   throughput is one word per cycle while m_tready is high; the interrupt
//   registers are updated when an item moves from the input register to
//   the result register.
//   when m_tready is low the result holds, the input register still takes
//   one word, and s_tready drops only once both registers are full.
//   reset clears both valid flags and the interrupt status and mask.
// ----------------------------------------------------------------------------
module bus_address_decoder_with_irq_regs_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // access_size[1:0], address[33:2], write_data[65:34], req_line[69:66]
    input  logic [badec_pkg::S_DATA_W-1:0]      s_tdata,
    // command[1:0]
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // target[2:0], offset[23:3], read_data[55:24], irq_flags[66:56]
    output logic [badec_pkg::M_DATA_W-1:0]      m_tdata,
    // status[2:0]
    output logic [2:0]                          m_tuser
);
    import badec_pkg::*;

    logic              in_vld_reg;
    logic              in_vld_next;
    cmd_t              in_cmd_reg;
    size_t             in_size_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [DATA_W-1:0] in_wdata_reg;
    logic [LINE_W-1:0] in_line_reg;

    logic              out_vld_reg;
    logic              out_vld_next;
    dec_t              out_dec_reg;
    logic [IRQ_W-1:0]  out_flags_reg;

    logic              s_fire;
    logic              adv;
    dec_t              dec;
    irq_op_t           op;
    logic [IRQ_W-1:0]  pending;
    logic [IRQ_W-1:0]  mask;
    logic [IRQ_W-1:0]  pending_after;

    assign adv          = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready     = !in_vld_reg || adv;
    assign s_fire       = s_tvalid && s_tready;
    assign in_vld_next  = s_fire || (in_vld_reg && !adv);
    assign out_vld_next = adv || (out_vld_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg   <= cmd_t'(s_tuser);
            in_size_reg  <= size_t'(s_tdata[1:0]);
            in_addr_reg  <= s_tdata[33:2];
            in_wdata_reg <= s_tdata[65:34];
            in_line_reg  <= s_tdata[69:66];
        end
        if (adv) begin
            out_dec_reg   <= dec;
            out_flags_reg <= pending_after;
        end
    end

    badec_decode u_decode (
        .cmd      (in_cmd_reg),
        .size     (in_size_reg),
        .addr     (in_addr_reg),
        .wdata    (in_wdata_reg),
        .req_line (in_line_reg),
        .pending  (pending),
        .mask     (mask),
        .dec      (dec),
        .op       (op)
    );

    badec_irq_regs u_irq_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .upd           (adv),
        .op            (op),
        .pending       (pending),
        .mask          (mask),
        .pending_after (pending_after)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'b0, out_flags_reg, out_dec_reg.rdata, out_dec_reg.offset,
                       out_dec_reg.target};
    assign m_tuser  = out_dec_reg.status;

endmodule

FILE: sim/tb_bus_address_decoder_with_irq_regs_top.sv
// ----------------------------------------------------------------------------
// tb_bus_address_decoder_with_irq_regs_top
// self-checking bench for the cpu bus address decoder with interrupt registers
// ----------------------------------------------------------------------------
// A queue of accesses (directed corner cases, then region-biased random
// traffic) feeds a stream driver. Every accepted word is run through a
// behavioral decoder with its own interrupt status and mask copies, and the
// outcome is stored by arrival order. The monitor compares each result word
// field by field. Both sides stall in random bursts; one long receiver
// hold-off fills the block and a few items wait for the pipe to drain.
// ----------------------------------------------------------------------------
module tb_bus_address_decoder_with_irq_regs_top;
    timeunit 1ns;
    timeprecision 1ps;

    import badec_pkg::*;

    localparam int RANDOM_ITEMS = 550;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 80;

    typedef struct {
        cmd_t        cmd;
        size_t       size;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic [3:0]  line;
        int          gap;
        bit          drain_first;
    } access_item_t;

    typedef struct packed {
        target_t           target;
        logic [OFF_W-1:0]  offset;
        logic [DATA_W-1:0] rdata;
        status_t           status;
        logic [IRQ_W-1:0]  flags;
    } decode_result_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic [1:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [2:0]            m_tuser;

    // decoder state as the bench sees it
    logic [IRQ_W-1:0]      irq_pending = '0;
    logic [IRQ_W-1:0]      irq_enable  = '0;

    access_item_t          stim_q[$];
    access_item_t          bus_item;
    decode_result_t        expected_results [0:1023];
    int                    in_count      = 0;
    int                    out_count     = 0;
    int                    mismatch_count = 0;
    int                    tx_gap        = 0;
    bit                    gap_taken     = 1'b0;
    bit                    quiet_tail    = 1'b0;
    int                    rx_gap        = 0;
    int                    rx_hold_left  = 0;
    bit                    hold_done     = 1'b0;

    bus_address_decoder_with_irq_regs_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // behavioral decoder
    // ------------------------------------------------------------------
    function automatic bit in_span(logic [31:0] p, logic [31:0] lo, logic [31:0] hi);
        return (p >= lo) && (p <= hi);
    endfunction

    function automatic decode_result_t forwarded(target_t t, logic [31:0] off);
        decode_result_t r;
        r.target = t;
        r.offset = off[OFF_W-1:0];
        r.rdata  = '0;
        r.status = ST_FWD;
        r.flags  = '0;
        return r;
    endfunction

    function automatic decode_result_t served(status_t st, logic [31:0] data);
        decode_result_t r;
        r.target = TGT_LOCAL;
        r.offset = '0;
        r.rdata  = data;
        r.status = st;
        r.flags  = '0;
        return r;
    endfunction

    function automatic decode_result_t decode_read(size_t sz, logic [31:0] p);
        if (sz == SZ_WORD) begin
            if (in_span(p, TMR_LO, TMR_HI)) return forwarded(TGT_TIMER, p - TMR_LO);
            if (p == IRQ_STAT_ADDR) return served(ST_LOCAL, 32'(irq_pending));
            if (p == INT_MASK_ADDR) return served(ST_LOCAL, 32'(irq_enable));
            if (p == GPU_LO) return forwarded(TGT_GP0, '0);
            if (p == GPU_P1) return forwarded(TGT_GP1, '0);
            if (in_span(p, DMA_LO, DMA_HI)) return forwarded(TGT_DMA, p - DMA_LO);
            if (in_span(p, BIOS_LO, BIOS_HI)) return forwarded(TGT_BIOS, p - BIOS_LO);
            if (p <= RAM_END) return forwarded(TGT_RAM, p);
            if (in_span(p, SPU_LO, SPU_HI)) return served(ST_IGN, '0);
            if (in_span(p, EXP1_LO, EXP1_HI)) return served(ST_LOCAL, EXP1_WORD);
            return served(ST_UNH, '0);
        end
        if (sz == SZ_HALF) begin
            if (in_span(p, TMR_LO, TMR_HI)) return forwarded(TGT_TIMER, p - TMR_LO);
            if (p == IRQ_STAT_ADDR) return served(ST_LOCAL, 32'(irq_pending));
            if (p == INT_MASK_ADDR) return served(ST_LOCAL, 32'(irq_enable));
            if (in_span(p, SPU_LO, SPU_HI)) return served(ST_IGN, '0);
            if (p <= RAM_END) return forwarded(TGT_RAM, p);
            if (in_span(p, EXP1_LO, EXP1_HI)) return served(ST_LOCAL, EXP1_HALF);
            return served(ST_UNH, '0);
        end
        if (in_span(p, TMR_LO, TMR_HI)) return served(ST_UNH, '0);
        if (in_span(p, CD_LO, CD_HI)) return served(ST_IGN, '0);
        if (in_span(p, EXP1_LO, EXP1_HI)) return served(ST_LOCAL, EXP1_BYTE);
        if (in_span(p, BIOS_LO, BIOS_HI)) return forwarded(TGT_BIOS, p - BIOS_LO);
        if (p <= RAM_END) return forwarded(TGT_RAM, p);
        return served(ST_UNH, '0);
    endfunction

    function automatic decode_result_t decode_write(size_t sz, logic [31:0] p,
                                                    logic [31:0] v);
        logic [31:0] val;
        bit          in_exp;
        in_exp = in_span(p, EXP1_LO, EXP1_HI) || in_span(p, EXP2_LO, EXP2_HI);
        val    = (sz == SZ_WORD) ? v : {16'h0, v[15:0]};
        if (sz != SZ_BYTE) begin
            if (in_span(p, TMR_LO, TMR_HI)) return forwarded(TGT_TIMER, p - TMR_LO);
            if (p == IRQ_STAT_ADDR) begin
                // write-one-to-clear acknowledge
                irq_pending = irq_pending & ~val[IRQ_W-1:0];
                return served(ST_LOCAL, '0);
            end
            if (p == INT_MASK_ADDR) begin
                irq_enable = val[IRQ_W-1:0];
                return served(ST_LOCAL, '0);
            end
            if (sz == SZ_WORD) begin
                if (p == CACHE_CTRL) return served(ST_IGN, '0);
                if (p == GPU_LO) return forwarded(TGT_GP0, '0);
                if (p == GPU_P1) return forwarded(TGT_GP1, '0);
                if (in_span(p, DMA_LO, DMA_HI)) return forwarded(TGT_DMA, p - DMA_LO);
                if (in_span(p, MEMC_LO, MEMC_HI)) return served(ST_IGN, '0);
                if (in_span(p, SPU_LO, SPU_HI)) return served(ST_IGN, '0);
                if (p <= RAM_END) return forwarded(TGT_RAM, p);
                if (in_span(p, BIOS_LO, BIOS_HI)) return served(ST_IGN, '0);
                if (in_exp) return served(ST_IGN, '0);
                return served(ST_UNH, '0);
            end
            if (in_span(p, SPU_LO, SPU_HI)) return served(ST_IGN, '0);
            if (p <= RAM_END) return forwarded(TGT_RAM, p);
            if (in_span(p, MEMC_LO, MEMC_HI)) return served(ST_IGN, '0);
            if (in_span(p, BIOS_LO, BIOS_HI)) return served(ST_IGN, '0);
            if (in_span(p, GPU_LO, GPU_HI)) return served(ST_UNH, '0);
            if (in_span(p, DMA_LO, DMA_HI)) return served(ST_UNH, '0);
            if (in_exp) return served(ST_IGN, '0);
            return served(ST_UNH, '0);
        end
        if (in_span(p, TMR_LO, TMR_HI)) return served(ST_UNH, '0);
        if (in_span(p, CD_LO, CD_HI)) return served(ST_IGN, '0);
        if (in_span(p, EXP2_LO, EXP2_HI)) return served(ST_IGN, '0);
        if (in_span(p, SPU_LO, SPU_HI)) return served(ST_IGN, '0);
        if (p <= RAM_END) return forwarded(TGT_RAM, p);
        if (in_span(p, MEMC_LO, MEMC_HI)) return served(ST_IGN, '0);
        if (in_span(p, BIOS_LO, BIOS_HI)) return served(ST_IGN, '0);
        if (in_span(p, EXP1_LO, EXP1_HI)) return served(ST_IGN, '0);
        return served(ST_UNH, '0);
    endfunction

    function automatic decode_result_t predict_access(access_item_t it);
        decode_result_t r;
        logic [31:0]    phys;
        bit             misaligned;
        r = served(ST_UNH, '0);
        if (it.cmd == CMD_IRQ) begin
            if (it.line <= IRQ_LINE_MAX) begin
                irq_pending[it.line] = 1'b1;
                r = served(ST_LOCAL, '0);
            end else begin
                r = served(ST_BADIRQ, '0);
            end
        end else if (it.cmd != CMD_RSVD && it.size != SZ_RSVD) begin
            misaligned = (it.size == SZ_WORD && it.addr[1:0] != 2'b00) ||
                         (it.size == SZ_HALF && it.addr[0]);
            if (misaligned) begin
                if (it.cmd == CMD_READ)
                    r = served(ST_MIS, (it.size == SZ_WORD) ? BAD_WORD : BAD_HALF);
                else
                    r = served(ST_MIS, '0);
            end else begin
                // segment mask picked by the top three address bits
                case (it.addr[31:29])
                    3'd4: begin
                        phys = it.addr & KSEG0_MASK;
                    end
                    3'd5: begin
                        phys = it.addr & KSEG1_MASK;
                    end
                    default: begin
                        phys = it.addr;
                    end
                endcase
                if (it.cmd == CMD_READ)
                    r = decode_read(it.size, phys);
                else
                    r = decode_write(it.size, phys, it.wdata);
            end
        end
        r.flags = irq_pending;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_access(cmd_t c, size_t sz, logic [31:0] a, logic [31:0] wd,
                              logic [3:0] ln);
        access_item_t it;
        it.cmd         = c;
        it.size        = sz;
        it.addr        = a;
        it.wdata       = wd;
        it.line        = ln;
        it.gap         = 0;
        it.drain_first = 1'b0;
        stim_q.push_back(it);
    endtask

    function automatic logic [31:0] boundary_addr(int k);
        case (k)
            0:  return RAM_END;
            1:  return RAM_END + 1;
            2:  return EXP1_LO - 1;
            3:  return EXP1_LO;
            4:  return EXP1_HI;
            5:  return EXP1_HI + 1;
            6:  return MEMC_LO;
            7:  return MEMC_HI;
            8:  return DMA_LO;
            9:  return DMA_HI;
            10: return TMR_LO;
            11: return TMR_HI;
            12: return TMR_HI + 1;
            13: return CD_LO;
            14: return CD_HI;
            15: return GPU_LO;
            16: return GPU_HI;
            17: return SPU_LO;
            18: return SPU_HI;
            19: return EXP2_LO;
            20: return EXP2_HI;
            21: return BIOS_LO - 1;
            22: return BIOS_LO;
            23: return BIOS_HI;
            default: return BIOS_HI + 1;
        endcase
    endfunction

    function automatic logic [31:0] pick_address(size_t sz);
        logic [31:0] p;
        int          k;
        k = $urandom_range(0, 19);
        case (k)
            0, 1, 2: p = $urandom_range(0, RAM_END);
            3:       p = EXP1_LO + $urandom_range(0, 32'h007f_ffff);
            4:       p = MEMC_LO + $urandom_range(0, 32'h7f);
            5, 6:    p = $urandom_range(0, 1) ? IRQ_STAT_ADDR : INT_MASK_ADDR;
            7:       p = DMA_LO + $urandom_range(0, 32'h7f);
            8:       p = TMR_LO + $urandom_range(0, 32'h2f);
            9:       p = CD_LO + $urandom_range(0, 3);
            10:      p = GPU_LO + $urandom_range(0, 7);
            11:      p = SPU_LO + $urandom_range(0, 32'h27f);
            12:      p = EXP2_LO + $urandom_range(0, 32'h41);
            13:      p = BIOS_LO + $urandom_range(0, 32'h7_ffff);
            14:      p = CACHE_CTRL;
            15, 16:  p = boundary_addr($urandom_range(0, 24));
            default: p = $urandom();
        endcase
        // reach physical regions through kuseg, kseg0 or kseg1
        if (k < 17 && p < 32'h2000_0000) begin
            case ($urandom_range(0, 2))
                1: begin
                    p = p | 32'h8000_0000;
                end
                2: begin
                    p = p | 32'ha000_0000;
                end
                default: begin
                end
            endcase
        end
        if ($urandom_range(0, 9) != 0) begin
            if (sz == SZ_WORD)
                p[1:0] = 2'b00;
            else if (sz == SZ_HALF)
                p[0] = 1'b0;
        end
        return p;
    endfunction

    function automatic access_item_t random_access(int idx);
        access_item_t it;
        int           k;
        k = $urandom_range(0, 99);
        if (k < 12)
            it.cmd = CMD_IRQ;
        else if (k < 15)
            it.cmd = CMD_RSVD;
        else if (k < 58)
            it.cmd = CMD_READ;
        else
            it.cmd = CMD_WRITE;
        k = $urandom_range(0, 19);
        it.size  = (k == 0) ? SZ_RSVD : size_t'(2'(k % 3));
        it.addr  = pick_address(it.size);
        it.wdata = $urandom();
        if ($urandom_range(0, 3) == 0)
            it.line = 4'($urandom_range(11, 15));
        else
            it.line = 4'($urandom_range(0, 10));
        it.drain_first = (idx == 0) || (idx == 300);
        // calm windows and the tail of the run carry no gaps
        if ((idx / 60) % 4 == 2 || idx >= RANDOM_ITEMS - 60 || $urandom_range(0, 5) != 0)
            it.gap = 0;
        else
            it.gap = $urandom_range(1, 14);
        return it;
    endfunction

    task automatic check_field(string fname, int idx, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("word %0d %s: expected %h got %h", idx, fname, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= CMD_READ;
            in_count   <= 0;
            tx_gap     <= 0;
            gap_taken  <= 1'b0;
            quiet_tail <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results[in_count] = predict_access(bus_item);
                in_count <= in_count + 1;
            end
            quiet_tail <= (stim_q.size() < 60);
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (stim_q.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (stim_q[0].drain_first && (s_tvalid || in_count != out_count)) begin
                    // hold back until every pending result is out
                    s_tvalid <= 1'b0;
                end else if (stim_q[0].gap != 0 && !gap_taken && rx_hold_left == 0) begin
                    tx_gap    <= stim_q[0].gap - 1;
                    gap_taken <= 1'b1;
                    s_tvalid  <= 1'b0;
                end else begin
                    bus_item  <= stim_q[0];
                    s_tdata   <= {2'b00, stim_q[0].line, stim_q[0].wdata, stim_q[0].addr,
                                  stim_q[0].size};
                    s_tuser   <= stim_q[0].cmd;
                    s_tvalid  <= 1'b1;
                    gap_taken <= 1'b0;
                    void'(stim_q.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver backpressure
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready     <= 1'b0;
            rx_gap       <= 0;
            rx_hold_left <= 0;
            hold_done    <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready     <= 1'b0;
        end else if (!hold_done && in_count >= HOLD_AT) begin
            rx_hold_left <= HOLD_CYCLES;
            hold_done    <= 1'b1;
            m_tready     <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap   <= rx_gap - 1;
            m_tready <= 1'b0;
        end else if (!quiet_tail && (in_count / 50) % 3 != 1 && $urandom_range(0, 7) == 0) begin
            rx_gap   <= $urandom_range(0, 13);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            out_count <= 0;
        end else if (m_tvalid && m_tready) begin
            if (out_count >= in_count) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("word %0d: result with nothing expected, tdata %h tuser %h",
                             out_count, m_tdata, m_tuser);
            end else begin
                check_field("target", out_count, 32'(expected_results[out_count].target),
                            32'(m_tdata[2:0]));
                check_field("offset", out_count, 32'(expected_results[out_count].offset),
                            32'(m_tdata[23:3]));
                check_field("read_data", out_count, expected_results[out_count].rdata,
                            m_tdata[55:24]);
                check_field("irq_flags", out_count, 32'(expected_results[out_count].flags),
                            32'(m_tdata[66:56]));
                check_field("status", out_count, 32'(expected_results[out_count].status),
                            32'(m_tuser));
            end
            out_count <= out_count + 1;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        int n;
        // interrupt lines: lowest, highest valid, first invalid, all ones
        add_access(CMD_IRQ,   SZ_WORD, 32'h0,         32'h0,         4'd0);
        add_access(CMD_IRQ,   SZ_BYTE, 32'h0,         32'h0,         4'd10);
        add_access(CMD_IRQ,   SZ_WORD, 32'hffff_ffff, 32'hffff_ffff, 4'd11);
        add_access(CMD_IRQ,   SZ_HALF, 32'h0,         32'h0,         4'd15);
        // status and mask registers, through kseg1 and kseg0
        add_access(CMD_READ,  SZ_WORD, 32'hbf80_1070, 32'h0,         4'd0);
        add_access(CMD_WRITE, SZ_WORD, INT_MASK_ADDR, 32'hffff_ffff, 4'd0);
        add_access(CMD_READ,  SZ_HALF, 32'h9f80_1074, 32'h0,         4'd0);
        add_access(CMD_WRITE, SZ_HALF, IRQ_STAT_ADDR, 32'h0000_0401, 4'd0);
        add_access(CMD_READ,  SZ_WORD, IRQ_STAT_ADDR, 32'h0,         4'd0);
        // misaligned accesses
        add_access(CMD_READ,  SZ_WORD, 32'h1f80_1072, 32'h0,         4'd0);
        add_access(CMD_READ,  SZ_HALF, 32'h0000_0001, 32'h0,         4'd0);
        add_access(CMD_WRITE, SZ_WORD, 32'h1f80_1075, 32'hffff_ffff, 4'd0);
        // reserved command and size
        add_access(CMD_RSVD,  SZ_WORD, 32'h0000_0000, 32'h0,         4'd0);
        add_access(CMD_READ,  SZ_RSVD, 32'h0000_0000, 32'h0,         4'd0);
        // address extremes and regions
        add_access(CMD_READ,  SZ_WORD, 32'h0000_0000, 32'h0,         4'd0);
        add_access(CMD_READ,  SZ_WORD, 32'hffff_fffc, 32'h0,         4'd0);
        add_access(CMD_READ,  SZ_BYTE, 32'hffff_ffff, 32'hffff_ffff, 4'd15);
        add_access(CMD_WRITE, SZ_WORD, CACHE_CTRL,    32'h0000_0000, 4'd0);
        add_access(CMD_READ,  SZ_WORD, 32'h9fc0_0000, 32'h0,         4'd0);
        add_access(CMD_READ,  SZ_BYTE, CD_LO,         32'h0,         4'd0);
        add_access(CMD_READ,  SZ_BYTE, EXP1_LO,       32'h0,         4'd0);
        add_access(CMD_READ,  SZ_HALF, 32'h1f7f_fffe, 32'h0,         4'd0);
        add_access(CMD_WRITE, SZ_WORD, GPU_P1,        32'h1234_5678, 4'd0);
        add_access(CMD_READ,  SZ_WORD, TMR_HI - 3,    32'h0,         4'd0);
        add_access(CMD_WRITE, SZ_BYTE, EXP2_LO,       32'h0000_00ff, 4'd0);
        for (n = 0; n < RANDOM_ITEMS; n++)
            stim_q.push_back(random_access(n));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        while (stim_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (out_count != in_count)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && out_count == in_count)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
